// ===== hdl/dpfc_pkg.sv =====
// Shared constants and types for the distinct prime factor counter.
`default_nettype none

package dpfc_pkg;

  // Largest value the factor table covers; the table holds 0 .. MAX_VALUE.
  localparam int unsigned MAX_VALUE = 1048575;
  localparam int unsigned DEPTH     = MAX_VALUE + 1;

  // Width of a table value, a table address and a walked-down query value.
  localparam int VW  = $clog2(DEPTH);
  // Sieve inner index, one bit of headroom above the table.
  localparam int JW  = VW + 1;
  // Square of the sieve prime.
  localparam int SQW = 2 * VW;

  localparam int QW = 20;  // query_value
  localparam int CW = 3;   // distinct_prime_count
  localparam logic [CW-1:0] COUNT_MAX = 3'd7;

  typedef logic [VW-1:0] val_t;

  // Access to the factor table.
  typedef struct packed {
    logic we;
    val_t waddr;
    val_t wdata;
    val_t raddr;
  } mem_req_t;

  // Request to the divider.
  typedef struct packed {
    logic start;
    val_t dividend;
    val_t divisor;
  } div_req_t;

endpackage

`default_nettype wire

// ===== hdl/dpfc_if.sv =====
// Valid/ready channel interfaces for queries and results.
`default_nettype none

interface dpfc_query_if;
  logic                   valid;
  logic                   ready;
  logic [dpfc_pkg::QW-1:0] query_value;

  modport source (output valid, output query_value, input ready);
  modport sink   (input valid, input query_value, output ready);
endinterface

interface dpfc_result_if;
  logic                   valid;
  logic                   ready;
  logic [dpfc_pkg::CW-1:0] distinct_prime_count;

  modport source (output valid, output distinct_prime_count, input ready);
  modport sink   (input valid, input distinct_prime_count, output ready);
endinterface

`default_nettype wire

// ===== hdl/dpfc_ram.sv =====
// Generic simple dual-port RAM, one write port and one registered read port.
`default_nettype none

module dpfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hdl/dpfc_div.sv =====
// Restoring divider, one quotient bit per cycle.
`default_nettype none

module dpfc_div (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire dpfc_pkg::div_req_t req,
  output      logic               done,
  output      dpfc_pkg::val_t     quotient
);

  localparam int CNTW = (dpfc_pkg::VW > 1) ? $clog2(dpfc_pkg::VW) : 1;

  logic                   busy_r;
  logic                   done_r;
  logic [CNTW-1:0]        cnt_r;
  dpfc_pkg::val_t         rem_r;
  dpfc_pkg::val_t         quo_r;
  dpfc_pkg::val_t         dsr_r;
  logic [dpfc_pkg::VW:0]  trial;
  logic                   fits;

  assign trial = {rem_r, quo_r[dpfc_pkg::VW-1]};
  assign fits  = trial >= {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == CNTW'(dpfc_pkg::VW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + CNTW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= req.dividend;
      dsr_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= fits ? dpfc_pkg::VW'(trial - {1'b0, dsr_r}) : dpfc_pkg::VW'(trial);
      quo_r <= {quo_r[dpfc_pkg::VW-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

// ===== hdl/dpfc_sieve.sv =====
// Table builder: clears the table, then fills smallest prime factors by sieve.
`default_nettype none

module dpfc_sieve (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire dpfc_pkg::val_t     rdata,
  output      dpfc_pkg::mem_req_t req,
  output      logic               built
);

  typedef enum logic [2:0] {
    S_CLEAR, S_OUT_RD, S_OUT_CHK, S_SQ, S_INNER, S_DONE
  } state_t;

  state_t                    state_r, state_nxt;
  dpfc_pkg::val_t            addr_r, addr_nxt;
  dpfc_pkg::val_t            i_r, i_nxt;
  logic [dpfc_pkg::JW-1:0]   j_r, j_nxt;
  logic [dpfc_pkg::SQW-1:0]  sq_r, sq_nxt;
  logic                      pend_r, pend_nxt;
  dpfc_pkg::val_t            pend_addr_r, pend_addr_nxt;
  logic                      last_i;

  assign last_i = i_r == dpfc_pkg::VW'(dpfc_pkg::MAX_VALUE);

  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    sq_nxt        = sq_r;
    pend_nxt      = pend_r;
    pend_addr_nxt = pend_addr_r;
    req.we        = 1'b0;
    req.waddr     = addr_r;
    req.wdata     = '0;
    req.raddr     = i_r;

    unique case (state_r)
      S_CLEAR: begin
        // entries 0 and 1 hold 1, all others start at 0 (no factor yet)
        req.we    = 1'b1;
        req.waddr = addr_r;
        req.wdata = (addr_r < dpfc_pkg::VW'(2)) ? dpfc_pkg::VW'(1) : '0;
        if (addr_r == dpfc_pkg::VW'(dpfc_pkg::MAX_VALUE)) begin
          i_nxt     = dpfc_pkg::VW'(2);
          state_nxt = S_OUT_RD;
        end else begin
          addr_nxt = addr_r + dpfc_pkg::VW'(1);
        end
      end
      S_OUT_RD: begin
        req.raddr = i_r;
        state_nxt = S_OUT_CHK;
      end
      S_OUT_CHK: begin
        if (rdata == '0) begin
          // i is prime
          req.we    = 1'b1;
          req.waddr = i_r;
          req.wdata = i_r;
          sq_nxt    = dpfc_pkg::SQW'(i_r) * dpfc_pkg::SQW'(i_r);
          state_nxt = S_SQ;
        end else if (last_i) begin
          state_nxt = S_DONE;
        end else begin
          i_nxt     = i_r + dpfc_pkg::VW'(1);
          state_nxt = S_OUT_RD;
        end
      end
      S_SQ: begin
        if (sq_r > dpfc_pkg::SQW'(dpfc_pkg::MAX_VALUE)) begin
          if (last_i) begin
            state_nxt = S_DONE;
          end else begin
            i_nxt     = i_r + dpfc_pkg::VW'(1);
            state_nxt = S_OUT_RD;
          end
        end else begin
          j_nxt     = dpfc_pkg::JW'(sq_r);
          pend_nxt  = 1'b0;
          state_nxt = S_INNER;
        end
      end
      S_INNER: begin
        // read at j while the entry read last cycle is written back if still 0
        if (pend_r && rdata == '0) begin
          req.we    = 1'b1;
          req.waddr = pend_addr_r;
          req.wdata = i_r;
        end
        if (j_r <= dpfc_pkg::JW'(dpfc_pkg::MAX_VALUE)) begin
          req.raddr     = dpfc_pkg::VW'(j_r);
          pend_nxt      = 1'b1;
          pend_addr_nxt = dpfc_pkg::VW'(j_r);
          j_nxt         = j_r + dpfc_pkg::JW'(i_r);
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            if (last_i) begin
              state_nxt = S_DONE;
            end else begin
              i_nxt     = i_r + dpfc_pkg::VW'(1);
              state_nxt = S_OUT_RD;
            end
          end
        end
      end
      S_DONE: begin
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      addr_r  <= '0;
      pend_r  <= 1'b0;
      built   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      addr_r  <= addr_nxt;
      pend_r  <= pend_nxt;
      built   <= state_nxt == S_DONE;
    end
  end

  always_ff @(posedge clk) begin
    i_r         <= i_nxt;
    j_r         <= j_nxt;
    sq_r        <= sq_nxt;
    pend_addr_r <= pend_addr_nxt;
  end

endmodule

`default_nettype wire

// ===== hdl/distinct_prime_factor_counter_top.sv =====
// Top level: factor table, sieve builder, divider and query walker.
//
//  channel   dir  handshake      payload
//  in_chan   in   valid/ready    query_value [19:0]
//  out_chan  out  valid/ready    distinct_prime_count [2:0]
//
// After reset the table is cleared and then sieved; in_chan.ready stays low
// until the sieve is done. A query walks one table read and one divide per
// prime factor counted with multiplicity. Results sit in an output register;
// a new query is taken while it waits.
`default_nettype none

module distinct_prime_factor_counter_top (
  input  wire logic          clk,
  input  wire logic          rst_n,
  dpfc_query_if.sink         in_chan,
  dpfc_result_if.source      out_chan
);

  typedef enum logic [1:0] {Q_IDLE, Q_LOOK, Q_DIV, Q_DONE} state_t;

  dpfc_pkg::mem_req_t       sieve_req;
  logic                     built;
  dpfc_pkg::val_t           rdata;
  dpfc_pkg::val_t           q_raddr;
  dpfc_pkg::val_t           raddr;
  dpfc_pkg::div_req_t       div_req;
  logic                     div_done;
  dpfc_pkg::val_t           div_quo;

  state_t                   state_r, state_nxt;
  dpfc_pkg::val_t           v_r, v_nxt;
  dpfc_pkg::val_t           prev_r, prev_nxt;
  logic [dpfc_pkg::CW-1:0]  count_r, count_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [dpfc_pkg::CW-1:0]  out_count_r, out_count_nxt;
  logic [31:0]              q_ext;
  logic                     accept;

  dpfc_sieve u_sieve (
    .clk   (clk),
    .rst_n (rst_n),
    .rdata (rdata),
    .req   (sieve_req),
    .built (built)
  );

  assign raddr = built ? q_raddr : sieve_req.raddr;

  dpfc_ram #(
    .WIDTH (dpfc_pkg::VW),
    .DEPTH (dpfc_pkg::DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (sieve_req.we),
    .waddr (sieve_req.waddr),
    .wdata (sieve_req.wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  dpfc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign q_ext          = 32'(in_chan.query_value);
  assign in_chan.ready  = built && state_r == Q_IDLE;
  assign accept         = in_chan.valid && in_chan.ready;

  always_comb begin
    state_nxt        = state_r;
    v_nxt            = v_r;
    prev_nxt         = prev_r;
    count_nxt        = count_r;
    out_valid_nxt    = out_valid_r && !out_chan.ready;
    out_count_nxt    = out_count_r;
    q_raddr          = v_r;
    div_req.start    = 1'b0;
    div_req.dividend = v_r;
    div_req.divisor  = rdata;

    unique case (state_r)
      Q_IDLE: begin
        if (accept) begin
          count_nxt = '0;
          prev_nxt  = '0;
          if (q_ext > 32'(dpfc_pkg::MAX_VALUE) || q_ext < 32'd2) begin
            state_nxt = Q_DONE;
          end else begin
            v_nxt     = dpfc_pkg::VW'(q_ext);
            q_raddr   = dpfc_pkg::VW'(q_ext);
            state_nxt = Q_LOOK;
          end
        end
      end
      Q_LOOK: begin
        // rdata is the smallest prime factor of v_r
        if (rdata < dpfc_pkg::VW'(2)) begin
          state_nxt = Q_DONE;
        end else begin
          if (rdata != prev_r) begin
            prev_nxt = rdata;
            if (count_r < dpfc_pkg::COUNT_MAX) begin
              count_nxt = count_r + dpfc_pkg::CW'(1);
            end
          end
          div_req.start = 1'b1;
          state_nxt     = Q_DIV;
        end
      end
      Q_DIV: begin
        if (div_done) begin
          v_nxt   = div_quo;
          q_raddr = div_quo;
          if (div_quo <= dpfc_pkg::VW'(1)) begin
            state_nxt = Q_DONE;
          end else begin
            state_nxt = Q_LOOK;
          end
        end
      end
      Q_DONE: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_count_nxt = count_r;
          state_nxt     = Q_IDLE;
        end
      end
      default: state_nxt = Q_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= Q_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    v_r         <= v_nxt;
    prev_r      <= prev_nxt;
    count_r     <= count_nxt;
    out_count_r <= out_count_nxt;
  end

  assign out_chan.valid                = out_valid_r;
  assign out_chan.distinct_prime_count = out_count_r;

  // No query is taken while the table is still being built.
  a_no_query_before_built: assert property (@(posedge clk) disable iff (!rst_n)
    !built |-> !in_chan.ready)
    else $error("query accepted before table built");

  // The table is never written once queries run.
  a_no_write_after_built: assert property (@(posedge clk) disable iff (!rst_n)
    built |-> !sieve_req.we)
    else $error("table write after build");

  // Every divide uses a divisor of at least two, never a table entry of 0 or 1.
  a_div_prime: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> div_req.divisor >= dpfc_pkg::VW'(2))
    else $error("divide by table entry below two");

  // A finished walk always lands in the output register.
  a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == Q_DONE && (!out_valid_r || out_chan.ready) |=>
      out_valid_r && out_count_r == $past(count_r))
    else $error("result not loaded");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking bench for the distinct prime factor counter, random idling and output stalls.
`default_nettype none

class prime_count_board;
  logic [dpfc_pkg::CW-1:0] expected_counts[$];
  int unsigned mismatches;

  function new();
    mismatches = 0;
  endfunction

  // Trial division up to sqrt(v); each prime found is stripped out completely.
  function logic [dpfc_pkg::CW-1:0] distinct_primes(logic [dpfc_pkg::QW-1:0] q);
    int unsigned v;
    int unsigned d;
    int unsigned n;
    v = q;
    n = 0;
    if (v > dpfc_pkg::MAX_VALUE) return '0;
    d = 2;
    while (d * d <= v) begin
      if (v % d == 0) begin
        n++;
        while (v % d == 0) v = v / d;
      end
      d++;
    end
    if (v > 1) n++;
    if (n > dpfc_pkg::COUNT_MAX) return dpfc_pkg::COUNT_MAX;
    return n[dpfc_pkg::CW-1:0];
  endfunction

  function void note_query(logic [dpfc_pkg::QW-1:0] q);
    expected_counts.push_back(distinct_primes(q));
  endfunction

  function void check_result(logic [dpfc_pkg::CW-1:0] got);
    logic [dpfc_pkg::CW-1:0] want;
    if (expected_counts.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual count %0d", $time, got);
      mismatches++;
      return;
    end
    want = expected_counts.pop_front();
    if (got !== want) begin
      $display("%0t: distinct_prime_count mismatch, expected %0d, actual %0d",
               $time, want, got);
      mismatches++;
    end
  endfunction
endclass

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int    ITEMS_PER_PHASE = 175;
  localparam int    DRAIN_CYCLES    = 600;
  // Clear plus sieve dominates; per item allow a full 19-factor walk plus stalls.
  localparam longint CYCLE_LIMIT    = 3 * 8 * longint'(dpfc_pkg::DEPTH) + 4000 * 725;
  localparam int unsigned SMALL_PRIMES [10] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29};

  logic   clk = 1'b0;
  logic   rst_n;
  longint cycles = 0;
  int     idle_pct;
  int     stall_pct;

  prime_count_board board;

  dpfc_query_if  query_ch ();
  dpfc_result_if result_ch ();

  distinct_prime_factor_counter_top uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (query_ch),
    .out_chan (result_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Result side: check on handshake, then pick ready for the next cycle.
  always @(posedge clk) begin
    if (rst_n && result_ch.valid && result_ch.ready) begin
      board.check_result(result_ch.distinct_prime_count);
    end
    result_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic send_query(input logic [dpfc_pkg::QW-1:0] v);
    while ($urandom_range(99) < idle_pct) begin
      query_ch.valid <= 1'b0;
      @(posedge clk);
    end
    query_ch.valid       <= 1'b1;
    query_ch.query_value <= v;
    do @(posedge clk); while (!query_ch.ready);
    board.note_query(v);
  endtask

  task automatic wait_all_results();
    query_ch.valid <= 1'b0;
    @(posedge clk);
    while (board.expected_counts.size() != 0) @(posedge clk);
  endtask

  function automatic logic [dpfc_pkg::QW-1:0] pick_query();
    longint unsigned v;
    int unsigned     p;
    int unsigned     base;
    v = 1;
    case ($urandom_range(9))
      0, 1, 2, 3, 4: v = $urandom & 32'hFFFFF;
      5: v = $urandom_range(0, 64);
      6: begin
        // smooth number: random product of small primes, repeats allowed
        repeat ($urandom_range(1, 20)) begin
          p = SMALL_PRIMES[$urandom_range(0, 9)];
          if (v * p <= dpfc_pkg::MAX_VALUE) v = v * p;
        end
      end
      7: begin
        // power of one prime, long walks of the same factor
        p = SMALL_PRIMES[$urandom_range(0, 9)];
        repeat ($urandom_range(1, 19)) if (v * p <= dpfc_pkg::MAX_VALUE) v = v * p;
      end
      8: v = 20'hFFFFF - $urandom_range(0, 255);
      default: begin
        // distinct primes in a row, aims at high counts
        base = $urandom_range(0, 3);
        for (int i = 0; i < 10; i++) begin
          p = SMALL_PRIMES[(base + i) % 10];
          if (v * p <= dpfc_pkg::MAX_VALUE) v = v * p;
        end
      end
    endcase
    return v[dpfc_pkg::QW-1:0];
  endfunction

  initial begin
    logic [dpfc_pkg::QW-1:0] directed [$];
    board                = new();
    rst_n                = 1'b0;
    idle_pct             = 0;
    stall_pct            = 0;
    query_ch.valid       = 1'b0;
    query_ch.query_value = '0;
    result_ch.ready      = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // zero, one, primes, prime powers, max count, field extremes, bit patterns
    directed = '{20'd0, 20'd1, 20'd2, 20'd3, 20'd4, 20'd6, 20'd30, 20'd97,
                 20'd524288, 20'd531441, 20'd510510, 20'd570570, 20'd746130,
                 20'd1042441, 20'd1048573, 20'd1048574, 20'hFFFFF, 20'hAAAAA,
                 20'h55555, 20'h80000, 20'h7FFFF, 20'd999983, 20'd9699};
    foreach (directed[i]) send_query(directed[i]);
    wait_all_results();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 56; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 56; end
        default: begin idle_pct = 18; stall_pct = 18; end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_query(pick_query());
        // hold off mid-phase until the block has emptied
        if (n == ITEMS_PER_PHASE / 2) wait_all_results();
      end
      wait_all_results();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.mismatches == 0 && board.expected_counts.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

`default_nettype wire

// ===== files.f =====
hdl/dpfc_pkg.sv
hdl/dpfc_if.sv
hdl/dpfc_ram.sv
hdl/dpfc_div.sv
hdl/dpfc_sieve.sv
hdl/distinct_prime_factor_counter_top.sv
tb/testbench.sv
